// ===== src/aie_pkg.sv =====
package aie_pkg;

    // Input item fields.
    typedef struct packed {
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [15:0]        elapsed;
    } t_in_item;

    // Result item fields.
    typedef struct packed {
        logic [1:0] intent;
        logic [6:0] confidence;
    } t_out_item;

    localparam int unsigned EnergyWidth = 64;
    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth = 32;

    // Configuration register indexes.
    localparam logic [CfgIndexWidth-1:0] CfgPolicy = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CfgEngage = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CfgRelease = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CfgActivation = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CfgWindow = 3'd4;

    // Intent codes.
    localparam logic [1:0] IntUndecided = 2'd0;
    localparam logic [1:0] IntFree = 2'd1;
    localparam logic [1:0] IntHoriz = 2'd2;
    localparam logic [1:0] IntVert = 2'd3;

    // Policy codes.
    localparam logic [1:0] PolFree = 2'd0;
    localparam logic [1:0] PolHoriz = 2'd1;
    localparam logic [1:0] PolVert = 2'd2;
    localparam logic [1:0] PolAdaptive = 2'd3;

endpackage

// ===== src/aie_muldiv.sv =====
// Bit-serial unsigned unit: multiplies a 64-bit operand by a 16-bit factor
// one multiplier bit a cycle, then optionally divides the 80-bit product by
// a divisor one quotient bit a cycle. Reports overflow of the product past
// 64 bits and the nonzero-remainder flag.
module aie_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_do_div,
    input  logic [63:0] i_a,
    input  logic [15:0] i_b,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [79:0] o_result,
    output logic        o_rem_nz,
    output logic        o_ovf
);
    import aie_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_DIV  = 3'b100
    } t_md_state;

    t_md_state   r_state, n_state;
    logic [6:0]  r_cnt, n_cnt;
    logic [79:0] r_acc, n_acc;
    logic [63:0] r_a, n_a;
    logic [15:0] r_b, n_b;
    logic [79:0] r_rem, n_rem;
    logic [63:0] r_dv, n_dv;
    logic        r_done, n_done;
    logic        r_ovf, n_ovf;

    logic [80:0] w_trial;

    assign w_trial = {r_rem, r_acc[79]} - {17'd0, r_dv};

    // Shift-add multiply, then an optional restoring division.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        n_rem   = r_rem;
        n_dv    = r_dv;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_MUL;
                    n_cnt   = 7'd0;
                    n_acc   = '0;
                    n_a     = i_a;
                    n_b     = i_b;
                    n_dv    = i_divisor;
                    n_ovf   = 1'b0;
                end
            end
            S_MUL: begin
                n_acc = {r_acc[78:0], 1'b0} + (r_b[15] ? {16'd0, r_a} : 80'd0);
                n_b   = {r_b[14:0], 1'b0};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd15) begin
                    // The full product is known here; flag it if it needs more than 64 bits.
                    n_ovf = (n_acc[79:64] != 16'd0);
                    n_cnt = 7'd0;
                    n_rem = '0;
                    if (i_do_div) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (!w_trial[80]) begin
                    n_rem = w_trial[79:0];
                    n_acc = {r_acc[78:0], 1'b1};
                end else begin
                    n_rem = {r_rem[78:0], r_acc[79]};
                    n_acc = {r_acc[78:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd79) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
        r_dv  <= n_dv;
        r_ovf <= n_ovf;
    end

    assign o_done   = r_done;
    assign o_result = r_acc;
    assign o_rem_nz = (r_rem != 80'd0);
    assign o_ovf    = r_ovf;

endmodule

// ===== src/axis_intent_estimator.sv =====
// Axis intent estimator. Each pointer report transfer yields one result
// transfer with the motion intent and a confidence percent. The work runs
// through one shared bit-serial multiply/divide unit: each operation is a
// multiply followed by a division, and it holds the sequencer until done.
// An adaptive report uses two decays, four dominance products and one
// confidence division; when the elapsed time reaches the window the two
// decays are skipped, and below the activation distance the dominance tests
// are skipped too. A forced horizontal or vertical policy uses only the
// confidence division; a free intent, a zero total energy or invalid
// settings answer without the unit. One report is worked on at a time, and
// the next is taken once the result register is free and no configuration
// transfer is offered. Configuration transfers are taken only while no
// report is being worked on.
module axis_intent_estimator (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  aie_pkg::t_in_item      i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output aie_pkg::t_out_item     o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    import aie_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECH   = 10'b0000000010,
        S_DECV   = 10'b0000000100,
        S_ACC    = 10'b0000001000,
        S_DOM    = 10'b0000010000,
        S_DECIDE = 10'b0000100000,
        S_CONF   = 10'b0001000000,
        S_OUT    = 10'b0010000000,
        S_WAITMD = 10'b0100000000,
        S_CSTART = 10'b1000000000
    } t_state;

    t_state      r_state, r_ret;
    logic [1:0]  r_policy;
    logic [15:0] r_engage, r_release, r_window;
    logic [31:0] r_activation;
    logic [63:0] r_eh, r_ev;
    logic [1:0]  r_intent;
    t_in_item    r_item;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [1:0]  r_dom_idx;
    logic [3:0]  r_dom;  // {v_rel, h_rel, v_eng, h_eng}
    logic [63:0] w_hs, w_vs;

    // Shared serial unit.
    logic        w_md_start, w_md_div, w_md_done, w_md_rnz, w_md_ovf;
    logic [63:0] w_md_a, w_md_div_by;
    logic [15:0] w_md_b;
    logic [79:0] w_md_res;

    aie_muldiv u_md (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_md_start),
        .i_do_div  (w_md_div),
        .i_a       (w_md_a),
        .i_b       (w_md_b),
        .i_divisor (w_md_div_by),
        .o_done    (w_md_done),
        .o_result  (w_md_res),
        .o_rem_nz  (w_md_rnz),
        .o_ovf     (w_md_ovf)
    );

    logic        w_invalid;
    logic [15:0] w_absx, w_absy;
    logic [15:0] w_rem_ms;
    logic [64:0] w_total;
    logic [63:0] w_total_sat;
    logic        w_decay_zero;
    logic [63:0] w_major;

    assign w_invalid = (r_engage == 16'd0) || (r_release == 16'd0) ||
                       (r_activation == 32'd0) || (r_window == 16'd0);
    assign w_absx = r_item.delta_x[15] ? 16'(-r_item.delta_x) : r_item.delta_x;
    assign w_absy = r_item.delta_y[15] ? 16'(-r_item.delta_y) : r_item.delta_y;
    assign w_decay_zero = (r_item.elapsed >= r_window);
    assign w_rem_ms = r_window - r_item.elapsed;
    assign w_total = {1'b0, r_eh} + {1'b0, r_ev};
    assign w_total_sat = w_total[64] ? '1 : w_total[63:0];
    assign w_major = (r_intent == IntHoriz) ? r_eh : r_ev;

    // Dominance operands: even index tests horizontal over vertical.
    logic [63:0] w_dom_minor, w_dom_majv;
    logic [15:0] w_dom_ratio;
    logic        w_dom_res;
    assign w_dom_minor = r_dom_idx[0] ? r_eh : r_ev;
    assign w_dom_majv  = r_dom_idx[0] ? r_ev : r_eh;
    assign w_dom_ratio = r_dom_idx[1] ? r_release : r_engage;
    assign w_dom_res   = w_md_ovf ||
        ({16'd0, w_dom_majv} >= (w_md_res + {79'd0, w_md_rnz}));

    always_comb begin
        w_md_start  = 1'b0;
        w_md_div    = 1'b1;
        w_md_a      = r_eh;
        w_md_b      = w_rem_ms;
        w_md_div_by = {48'd0, r_window};
        case (r_state)
            S_DECH: w_md_start = !w_decay_zero;
            S_DECV: begin
                w_md_start = !w_decay_zero;
                w_md_a     = r_ev;
            end
            S_DOM: begin
                w_md_start  = 1'b1;
                w_md_a      = w_dom_minor;
                w_md_b      = w_dom_ratio;
                w_md_div_by = 64'd100;
            end
            S_CSTART: begin
                w_md_start  = 1'b1;
                w_md_a      = w_major;
                w_md_b      = 16'd100;
                w_md_div_by = w_total_sat;
            end
            default: w_md_start = 1'b0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Saturated sums of decayed energy and new motion.
    logic [64:0] w_hsum, w_vsum;
    assign w_hsum = {1'b0, r_eh} + {49'd0, w_absx};
    assign w_vsum = {1'b0, r_ev} + {49'd0, w_absy};
    assign w_hs = w_hsum[64] ? '1 : w_hsum[63:0];
    assign w_vs = w_vsum[64] ? '1 : w_vsum[63:0];

    // Sequencer for one report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_policy     <= PolAdaptive;
            r_engage     <= 16'd200;
            r_release    <= 16'd120;
            r_activation <= 32'd16;
            r_window     <= 16'd250;
            r_eh         <= '0;
            r_ev         <= '0;
            r_intent     <= IntUndecided;
            r_dom_idx    <= 2'd0;
            r_dom        <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // Configuration transfers.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CfgPolicy:     r_policy <= i_cfg_data[1:0];
                    CfgEngage:     r_engage <= i_cfg_data[15:0];
                    CfgRelease:    r_release <= i_cfg_data[15:0];
                    CfgActivation: r_activation <= i_cfg_data;
                    CfgWindow:     r_window <= i_cfg_data[15:0];
                    default:       ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_item <= i_in_data;
                        if (w_invalid) begin
                            r_out.intent     <= IntFree;
                            r_out.confidence <= 7'd0;
                            r_state          <= S_OUT;
                        end else begin
                            case (r_policy)
                                PolFree: begin
                                    r_intent <= IntFree;
                                    r_state  <= S_CONF;
                                end
                                PolHoriz: begin
                                    r_intent <= IntHoriz;
                                    r_state  <= S_CONF;
                                end
                                PolVert: begin
                                    r_intent <= IntVert;
                                    r_state  <= S_CONF;
                                end
                                default: r_state <= S_DECH;
                            endcase
                        end
                    end
                end
                S_DECH: begin
                    if (w_decay_zero) begin
                        r_eh    <= '0;
                        r_state <= S_DECV;
                    end else begin
                        r_ret   <= S_DECH;
                        r_state <= S_WAITMD;
                    end
                end
                S_DECV: begin
                    if (w_decay_zero) begin
                        r_ev    <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_ret   <= S_DECV;
                        r_state <= S_WAITMD;
                    end
                end
                S_ACC: begin
                    r_eh      <= w_hs;
                    r_ev      <= w_vs;
                    r_dom_idx <= 2'd0;
                    r_state   <= S_DECIDE;
                    r_ret     <= S_ACC;
                end
                S_DOM: begin
                    r_ret   <= S_DOM;
                    r_state <= S_WAITMD;
                end
                S_WAITMD: begin
                    if (w_md_done) begin
                        case (r_ret)
                            S_DECH: begin
                                r_eh    <= w_md_ovf ? '1 : w_md_res[63:0];
                                r_state <= S_DECV;
                            end
                            S_DECV: begin
                                r_ev    <= w_md_ovf ? '1 : w_md_res[63:0];
                                r_state <= S_ACC;
                            end
                            S_DOM: begin
                                r_dom[r_dom_idx] <= w_dom_res;
                                r_dom_idx        <= r_dom_idx + 2'd1;
                                r_state          <= (r_dom_idx == 2'd3) ? S_DECIDE
                                                                        : S_DOM;
                            end
                            default: begin
                                r_out.intent <= r_intent;
                                r_out.confidence <= (w_major > 64'd184467440737095516)
                                    ? 7'd100 : w_md_res[6:0];
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_DECIDE: begin
                    if (r_ret == S_ACC) begin
                        // Just accumulated: gate on activation distance.
                        if (w_total_sat >= {32'd0, r_activation}) begin
                            r_state <= S_DOM;
                        end else begin
                            r_state <= S_CONF;
                        end
                    end else begin
                        if (r_intent == IntHoriz) begin
                            if (!r_dom[2]) r_intent <= r_dom[1] ? IntVert : IntFree;
                        end else if (r_intent == IntVert) begin
                            if (!r_dom[3]) r_intent <= r_dom[0] ? IntHoriz : IntFree;
                        end else begin
                            r_intent <= r_dom[0] ? IntHoriz :
                                        (r_dom[1] ? IntVert : IntFree);
                        end
                        r_state <= S_CONF;
                    end
                end
                S_CONF: begin
                    if ((r_intent != IntHoriz && r_intent != IntVert) ||
                        (w_total_sat == 64'd0)) begin
                        r_out.intent     <= r_intent;
                        r_out.confidence <= 7'd0;
                        r_state          <= S_OUT;
                    end else begin
                        r_state <= S_CSTART;
                    end
                end
                S_CSTART: begin
                    r_ret   <= S_CONF;
                    r_state <= S_WAITMD;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/intent_checker.sv =====
`timescale 1ns / 1ps

// Watches the report and result channels, predicts each result from the
// configuration writes it observes, and compares in arrival order.
module intent_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  aie_pkg::t_in_item     i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  aie_pkg::t_out_item    i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count
);
    import aie_pkg::*;

    localparam logic [63:0] Sat = 64'hFFFF_FFFF_FFFF_FFFF;

    // Predictor copy of the configuration and state.
    logic [1:0]  policy;
    logic [15:0] engage_pct;
    logic [15:0] release_pct;
    logic [31:0] activation;
    logic [15:0] decay_span;
    logic [63:0] energy_h;
    logic [63:0] energy_v;
    logic [1:0]  intent_now;

    t_out_item expected_results[$];

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? Sat : s[63:0];
    endfunction

    function automatic logic [63:0] decay_energy(input logic [63:0] e, input logic [15:0] ms,
                                                 input logic [15:0] win);
        logic [127:0] p;
        if (ms >= win) return 64'd0;
        p = e * (128'(win - ms));
        if (p[127:64] != 0) return Sat;
        return p[63:0] / 64'(win);
    endfunction

    // Major dominates minor when major >= ceil(minor * ratio / 100), or when the product needs more than 64 bits.
    function automatic logic dominates(input logic [63:0] major, input logic [63:0] minor,
                                       input logic [15:0] ratio);
        logic [127:0] p;
        logic [63:0] need;
        p = minor * 128'(ratio);
        if (p[127:64] != 0) return 1'b1;
        need = p[63:0] / 100 + ((p[63:0] % 100) != 0 ? 64'd1 : 64'd0);
        return major >= need;
    endfunction

    function automatic logic [6:0] confidence_pct();
        logic [63:0] major;
        logic [63:0] total;
        logic [127:0] p;
        if (intent_now != IntHoriz && intent_now != IntVert) return 7'd0;
        major = (intent_now == IntHoriz) ? energy_h : energy_v;
        total = add_sat(energy_h, energy_v);
        if (total == 0) return 7'd0;
        p = major * 128'd100;
        if (p[127:64] != 0) return 7'd100;
        return 7'(p[63:0] / total);
    endfunction

    function automatic t_out_item predict_intent(input t_in_item item);
        t_out_item res;
        logic h_eng;
        logic v_eng;
        logic [63:0] total;
        if (engage_pct == 0 || release_pct == 0 || activation == 0 || decay_span == 0) begin
            res.intent = IntFree;
            res.confidence = 7'd0;
            return res;
        end
        case (policy)
            PolFree: intent_now = IntFree;
            PolHoriz: intent_now = IntHoriz;
            PolVert: intent_now = IntVert;
            default: begin
                energy_h = add_sat(decay_energy(energy_h, item.elapsed, decay_span),
                                   64'(item.delta_x < 0 ? -17'(item.delta_x) : 17'(item.delta_x)));
                energy_v = add_sat(decay_energy(energy_v, item.elapsed, decay_span),
                                   64'(item.delta_y < 0 ? -17'(item.delta_y) : 17'(item.delta_y)));
                total = add_sat(energy_h, energy_v);
                if (total >= 64'(activation)) begin
                    h_eng = dominates(energy_h, energy_v, engage_pct);
                    v_eng = dominates(energy_v, energy_h, engage_pct);
                    if (intent_now == IntHoriz) begin
                        if (!dominates(energy_h, energy_v, release_pct))
                            intent_now = v_eng ? IntVert : IntFree;
                    end else if (intent_now == IntVert) begin
                        if (!dominates(energy_v, energy_h, release_pct))
                            intent_now = h_eng ? IntHoriz : IntFree;
                    end else begin
                        intent_now = h_eng ? IntHoriz : (v_eng ? IntVert : IntFree);
                    end
                end
            end
        endcase
        res.intent = intent_now;
        res.confidence = confidence_pct();
        return res;
    endfunction

    assign o_pending = expected_results.size();

    // Track configuration writes, report transfers and result transfers.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            policy <= PolAdaptive;
            engage_pct <= 16'd200;
            release_pct <= 16'd120;
            activation <= 32'd16;
            decay_span <= 16'd250;
            energy_h = 64'd0;
            energy_v = 64'd0;
            intent_now = IntUndecided;
            expected_results.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CfgPolicy: policy <= i_cfg_data[1:0];
                    CfgEngage: engage_pct <= i_cfg_data[15:0];
                    CfgRelease: release_pct <= i_cfg_data[15:0];
                    CfgActivation: activation <= i_cfg_data;
                    CfgWindow: decay_span <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(predict_intent(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (expected_results.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("Unexpected result: intent %0d confidence %0d",
                                 i_out_data.intent, i_out_data.confidence);
                end else begin
                    want = expected_results.pop_front();
                    if (want.intent !== i_out_data.intent ||
                        want.confidence !== i_out_data.confidence) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("Mismatch: expected intent %0d conf %0d, got %0d conf %0d",
                                     want.intent, want.confidence,
                                     i_out_data.intent, i_out_data.confidence);
                    end
                end
            end
        end
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Drives reports and configuration writes; the checker judges the results.
module testbench;
    import aie_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          result_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int unsigned cycle_count;
    int          report_count;

    axis_intent_estimator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    intent_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Cycle limit: room for roughly 700 reports with stalls, many times over.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3_000_000) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_report(input logic signed [15:0] dx, input logic signed [15:0] dy,
                               input logic [15:0] ms);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid <= 1'b1;
        in_data <= '{delta_x: dx, delta_y: dy, elapsed: ms};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid <= 1'b0;
        report_count++;
    endtask

    // Waits until every result is back, then lets the block settle.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_report();
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] ms;
        int mode;
        mode = $urandom_range(9);
        dx = $urandom;
        dy = $urandom;
        ms = $urandom_range(60);
        // Mostly small motion with one axis leaning, so locks engage and release.
        if (mode < 4) begin
            dx = $urandom_range(40);
            dy = $urandom_range(8);
        end else if (mode < 8) begin
            dx = $urandom_range(8);
            dy = $urandom_range(40);
        end else if (mode == 8) begin
            ms = $urandom;
        end
        if ($urandom_range(1)) dx = -dx;
        if ($urandom_range(1)) dy = -dy;
        send_report(dx, dy, ms);
    endtask

    task automatic random_settings();
        write_reg(CfgPolicy, ($urandom_range(9) < 7) ? PolAdaptive : 2'($urandom_range(2)));
        write_reg(CfgEngage, $urandom_range(101, 400));
        write_reg(CfgRelease, $urandom_range(100, 200));
        write_reg(CfgActivation, $urandom_range(1, 100));
        write_reg(CfgWindow, $urandom_range(1, 500));
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        report_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, extremes of the deltas and elapsed time.
        send_report(16'sd0, 16'sd0, 16'd0);
        send_report(16'sd30, 16'sd1, 16'd5);
        send_report(16'sd2, 16'sd40, 16'd5);
        send_report(-16'sd32768, 16'sd32767, 16'd0);
        send_report(16'sd32767, -16'sd32768, 16'd65535);
        send_report(-16'sd1, -16'sd1, 16'd249);
        send_report(16'sd20, 16'sd20, 16'd250);
        drain();
        // Extreme settings: a maximum window with zero elapsed time keeps the energies growing.
        write_reg(CfgWindow, 32'hFFFF);
        write_reg(CfgActivation, 32'hFFFF_FFFF);
        write_reg(CfgEngage, 32'hFFFF);
        write_reg(CfgRelease, 32'hFFFF);
        repeat (4) send_report(-16'sd32768, 16'sd5, 16'd0);
        send_report(16'sd0, 16'sd0, 16'd1);
        drain();
        // Forced policies, then each invalid zero setting and a write to an unused index.
        write_reg(CfgPolicy, PolFree);
        send_report(16'sd3, 16'sd3, 16'd3);
        write_reg(CfgPolicy, PolHoriz);
        send_report(16'sd3, 16'sd3, 16'd3);
        write_reg(CfgPolicy, PolVert);
        send_report(16'sd3, 16'sd3, 16'd3);
        write_reg(CfgPolicy, PolAdaptive);
        write_reg(CfgEngage, 0);
        send_report(16'sd9, 16'sd0, 16'd1);
        write_reg(CfgEngage, 200);
        write_reg(CfgRelease, 0);
        send_report(16'sd9, 16'sd0, 16'd1);
        write_reg(CfgRelease, 120);
        write_reg(CfgActivation, 0);
        send_report(16'sd9, 16'sd0, 16'd1);
        write_reg(CfgActivation, 16);
        write_reg(CfgWindow, 0);
        send_report(16'sd9, 16'sd0, 16'd1);
        write_reg(CfgWindow, 250);
        write_reg(3'd7, 32'hDEAD_BEEF);
        send_report(16'sd9, 16'sd0, 16'd1);
        drain();

        // Random phases: receiver idles more, then sender, then neither.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 68 : 0;
            recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 38 : 0;
            for (int blk = 0; blk < 6; blk++) begin
                random_settings();
                repeat (38) random_report();
                drain();
            end
        end

        $display("Covered %0d reports and %0d results over forced, adaptive and invalid settings.",
                 report_count, result_count);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/aie_pkg.sv
src/aie_muldiv.sv
src/axis_intent_estimator.sv
dv/intent_checker.sv
dv/testbench.sv
